### hdl/gcfh_pkg.sv
// Shared constants, types and the reset class mapping of the class fraction histogram.
package gcfh_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int SUM_BITS    = 40;

    localparam int CLS_BITS  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IDX_BITS  = $clog2(TABLE_DEPTH);
    localparam int TOT_BITS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int STEP_BITS = $clog2(FRAC_BITS);
    localparam int CELL_BITS = 20;
    localparam int CODE_BITS = 8;
    localparam int NCLS_BITS = 3;
    localparam int CNT_BITS  = 32;

    localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};
    localparam logic [TOT_BITS-1:0]  TOT_MAX  = {TOT_BITS{1'b1}};
    localparam logic [FRAC_BITS-1:0] FRAC_MAX = {FRAC_BITS{1'b1}};

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] sum;
        logic [TOT_BITS-1:0] total;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quo;
    } t_div_rsp;

    // Class a raw code maps to after reset; unlisted codes give class 0.
    function automatic logic [CLS_BITS-1:0] init_class(input logic [CODE_BITS-1:0] code);
        int c;
        c = 0;
        case (code)
            8'd170, 8'd150, 8'd106, 8'd173, 8'd109, 8'd102, 8'd49,
            8'd151, 8'd90,  8'd157, 8'd107, 8'd93,  8'd96,  8'd122: begin
                c = 1;
            end
            8'd19, 8'd31, 8'd41, 8'd45, 8'd32, 8'd18, 8'd42: begin
                c = 2;
            end
            8'd11, 8'd12, 8'd44, 8'd38, 8'd78, 8'd81: begin
                c = 3;
            end
            8'd23, 8'd25, 8'd36, 8'd22, 8'd16, 8'd24, 8'd30: begin
                c = 4;
            end
            8'd26, 8'd27, 8'd29, 8'd28, 8'd37, 8'd128,
            8'd54, 8'd92, 8'd53, 8'd124, 8'd94, 8'd73: begin
                c = 5;
            end
            8'd139, 8'd135, 8'd138, 8'd40, 8'd116, 8'd145, 8'd144,
            8'd117, 8'd137, 8'd136, 8'd141, 8'd21, 8'd147: begin
                c = 6;
            end
            8'd120, 8'd123, 8'd121, 8'd127, 8'd126, 8'd129, 8'd132: begin
                c = 7;
            end
            default: begin
                c = 0;
            end
        endcase
        if (c >= NUM_CLASSES) begin
            c = NUM_CLASSES - 1;
        end
        return CLS_BITS'(c);
    endfunction

endpackage

### hdl/gcfh_table.sv
// Reclassification table: RAM with per-entry valid bits, reset mapping for unwritten entries.
module gcfh_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [gcfh_pkg::IDX_BITS-1:0] i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [gcfh_pkg::IDX_BITS-1:0] i_wr_addr,
    input  logic [gcfh_pkg::CLS_BITS-1:0] i_wr_data,
    output logic [gcfh_pkg::CLS_BITS-1:0] o_rd_cls
);

    logic [gcfh_pkg::CLS_BITS-1:0] r_mem [gcfh_pkg::TABLE_DEPTH];
    logic [gcfh_pkg::TABLE_DEPTH-1:0] r_wr_valid;
    logic [gcfh_pkg::CLS_BITS-1:0] r_q;
    logic [gcfh_pkg::CLS_BITS-1:0] r_init_q;
    logic                          r_v_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q      <= r_mem[i_rd_addr];
            r_init_q <= gcfh_pkg::init_class(gcfh_pkg::CODE_BITS'(i_rd_addr));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= '0;
            r_v_q      <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_wr_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_v_q <= r_wr_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_cls = r_v_q ? r_q : r_init_q;

endmodule

### hdl/gcfh_div.sv
// Shared fraction divider: floor(sum * 2^16 / total), saturating, one quotient bit per cycle.
module gcfh_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gcfh_pkg::t_div_req i_req,
    output gcfh_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [gcfh_pkg::STEP_BITS-1:0]  r_step;
    logic [gcfh_pkg::TOT_BITS-1:0]   r_rem;
    logic [gcfh_pkg::TOT_BITS-1:0]   r_den;
    logic [gcfh_pkg::FRAC_BITS-1:0]  r_quo;

    logic [gcfh_pkg::TOT_BITS-1:0]   sum_ext;
    logic [gcfh_pkg::TOT_BITS:0]     shifted;
    logic [gcfh_pkg::TOT_BITS:0]     den_ext;
    logic                            ge;
    logic                            last_step;

    assign sum_ext   = gcfh_pkg::TOT_BITS'(i_req.sum);
    assign shifted   = {r_rem, 1'b0};
    assign den_ext   = {1'b0, r_den};
    assign ge        = (shifted >= den_ext);
    assign last_step = (r_step == gcfh_pkg::STEP_BITS'(gcfh_pkg::FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            // zero total and full share finish at once
            if (i_req.total == '0 || sum_ext >= i_req.total) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end
        end else if (r_busy && last_step) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den  <= i_req.total;
            r_rem  <= sum_ext;
            r_step <= '0;
            if (i_req.total == '0) begin
                r_quo <= '0;
            end else if (sum_ext >= i_req.total) begin
                r_quo <= gcfh_pkg::FRAC_MAX;
            end else begin
                r_quo <= '0;
            end
        end else if (r_busy) begin
            r_rem  <= ge ? gcfh_pkg::TOT_BITS'(shifted - den_ext)
                         : shifted[gcfh_pkg::TOT_BITS-1:0];
            r_quo  <= {r_quo[gcfh_pkg::FRAC_BITS-2:0], ge};
            r_step <= r_step + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### hdl/grouped_class_fraction_histogram_unit.sv
// Grouped class fraction histogram: sequencer, class sums and output register.
// Add record: table read, then saturating add into the class sum.
// Table write and flush of a closed cell finish in the idle state. Input stalls while busy.
// Cell emit: S_TOTAL totals the class sums, then per class S_DSTART starts the shared
// bit-serial divider and S_DWAIT loads its quotient into the output register when free.
// Reset (sync, active low) clears sums, cell state and table write marks.
module grouped_class_fraction_histogram_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_cmd,
    input  logic [gcfh_pkg::CELL_BITS-1:0] i_cell_id,
    input  logic [gcfh_pkg::CODE_BITS-1:0] i_raw_code,
    input  logic [gcfh_pkg::CNT_BITS-1:0]  i_pixel_count,
    input  logic [gcfh_pkg::NCLS_BITS-1:0] i_new_class,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [gcfh_pkg::CELL_BITS-1:0] o_out_cell,
    output logic [2:0]                     o_class_index,
    output logic [gcfh_pkg::FRAC_BITS-1:0] o_fraction,
    output logic                           o_last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_TOTAL  = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;

    localparam logic [gcfh_pkg::CLS_BITS-1:0] K_LAST =
        gcfh_pkg::CLS_BITS'(gcfh_pkg::NUM_CLASSES - 1);

    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    logic [gcfh_pkg::SUM_BITS-1:0]   r_sums [gcfh_pkg::NUM_CLASSES];
    logic [gcfh_pkg::CELL_BITS-1:0]  r_cur;
    logic                            r_open;
    logic                            r_add_pend;
    logic [gcfh_pkg::CELL_BITS-1:0]  r_cell;
    logic [gcfh_pkg::CNT_BITS-1:0]   r_cnt;
    logic                            r_code_ok;
    logic [gcfh_pkg::CLS_BITS-1:0]   r_k;
    logic [gcfh_pkg::TOT_BITS-1:0]   r_total;
    logic                            r_ovalid;
    logic [gcfh_pkg::CELL_BITS-1:0]  r_ocell;
    logic [2:0]                      r_oidx;
    logic [gcfh_pkg::FRAC_BITS-1:0]  r_ofrac;
    logic                            r_olast;

    logic                            accept;
    logic                            code_ok;
    logic                            wr_en;
    logic [gcfh_pkg::CLS_BITS-1:0]   tbl_cls;
    logic [gcfh_pkg::CLS_BITS-1:0]   add_cls;
    logic [gcfh_pkg::SUM_BITS:0]     add_sum;
    logic [gcfh_pkg::SUM_BITS-1:0]   k_sum;
    logic [gcfh_pkg::TOT_BITS:0]     tot_sum;
    logic                            out_free;
    logic                            load_out;
    gcfh_pkg::t_div_req              div_req;
    gcfh_pkg::t_div_rsp              div_rsp;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign code_ok = (32'(i_raw_code) < gcfh_pkg::TABLE_DEPTH);
    assign wr_en   = accept && (i_cmd == gcfh_pkg::CMD_WRITE) && code_ok &&
                     (32'(i_new_class) < gcfh_pkg::NUM_CLASSES);

    gcfh_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (gcfh_pkg::IDX_BITS'(i_raw_code)),
        .i_wr_en   (wr_en),
        .i_wr_addr (gcfh_pkg::IDX_BITS'(i_raw_code)),
        .i_wr_data (gcfh_pkg::CLS_BITS'(i_new_class)),
        .o_rd_cls  (tbl_cls)
    );

    // out-of-range codes and classes land in class 0
    always_comb begin
        add_cls = r_code_ok ? tbl_cls : '0;
        if (32'(add_cls) >= gcfh_pkg::NUM_CLASSES) begin
            add_cls = '0;
        end
    end

    assign add_sum = {1'b0, r_sums[add_cls]} + (gcfh_pkg::SUM_BITS + 1)'(r_cnt);
    assign k_sum   = r_sums[r_k];
    assign tot_sum = {1'b0, r_total} + (gcfh_pkg::TOT_BITS + 1)'(k_sum);

    assign div_req.start = (r_state == S_DSTART);
    assign div_req.sum   = k_sum;
    assign div_req.total = r_total;

    gcfh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_ovalid || !i_stall;
    assign load_out = (r_state == S_DWAIT) && div_rsp.done && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == gcfh_pkg::CMD_ADD) begin
                        n_state = (r_open && i_cell_id != r_cur) ? S_TOTAL : S_ADD;
                    end else if (i_cmd == gcfh_pkg::CMD_FLUSH && r_open) begin
                        n_state = S_TOTAL;
                    end
                end
            end
            S_ADD: begin
                n_state = S_IDLE;
            end
            S_TOTAL: begin
                if (r_k == K_LAST) begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (load_out) begin
                    if (r_k == K_LAST) begin
                        n_state = r_add_pend ? S_ADD : S_IDLE;
                    end else begin
                        n_state = S_DSTART;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur      <= '0;
            r_open     <= 1'b0;
            r_add_pend <= 1'b0;
            r_k        <= '0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < gcfh_pkg::NUM_CLASSES; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (accept) begin
                        r_add_pend <= (i_cmd == gcfh_pkg::CMD_ADD);
                    end
                end
                S_ADD: begin
                    r_sums[add_cls] <= add_sum[gcfh_pkg::SUM_BITS] ? gcfh_pkg::SUM_MAX
                                       : add_sum[gcfh_pkg::SUM_BITS-1:0];
                    r_cur  <= r_cell;
                    r_open <= 1'b1;
                end
                S_TOTAL: begin
                    r_k <= (r_k == K_LAST) ? '0 : r_k + 1'b1;
                end
                S_DWAIT: begin
                    if (load_out) begin
                        if (r_k == K_LAST) begin
                            r_k <= '0;
                            for (int i = 0; i < gcfh_pkg::NUM_CLASSES; i++) begin
                                r_sums[i] <= '0;
                            end
                            if (!r_add_pend) begin
                                r_open <= 1'b0;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell    <= i_cell_id;
            r_cnt     <= i_pixel_count;
            r_code_ok <= code_ok;
        end
        if (r_state == S_IDLE) begin
            r_total <= '0;
        end else if (r_state == S_TOTAL) begin
            r_total <= tot_sum[gcfh_pkg::TOT_BITS] ? gcfh_pkg::TOT_MAX
                       : tot_sum[gcfh_pkg::TOT_BITS-1:0];
        end
        if (load_out) begin
            r_ocell <= r_cur;
            r_oidx  <= 3'(r_k);
            r_ofrac <= div_rsp.quo;
            r_olast <= (r_k == K_LAST);
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_cell    = r_ocell;
    assign o_class_index = r_oidx;
    assign o_fraction    = r_ofrac;
    assign o_last        = r_olast;

endmodule

### tb/grouped_class_fraction_histogram_unit_tb.sv
// Self-checking testbench: per-cell class fractions predicted in SV and compared per transfer.
module grouped_class_fraction_histogram_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N_MAPPED = 66;

    typedef struct {
        logic [1:0]                     cmd;
        logic [gcfh_pkg::CELL_BITS-1:0] grid_cell;
        logic [gcfh_pkg::CODE_BITS-1:0] code;
        logic [gcfh_pkg::CNT_BITS-1:0]  count;
        logic [gcfh_pkg::NCLS_BITS-1:0] ncls;
    } t_land_rec;

    typedef struct {
        logic [gcfh_pkg::CELL_BITS-1:0] grid_cell;
        logic [2:0]                     cls;
        logic [gcfh_pkg::FRAC_BITS-1:0] frac;
        logic                           last;
    } t_frac_word;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [1:0]                     i_cmd;
    logic [gcfh_pkg::CELL_BITS-1:0] i_cell_id;
    logic [gcfh_pkg::CODE_BITS-1:0] i_raw_code;
    logic [gcfh_pkg::CNT_BITS-1:0]  i_pixel_count;
    logic [gcfh_pkg::NCLS_BITS-1:0] i_new_class;
    logic                           o_valid;
    logic                           i_stall;
    logic [gcfh_pkg::CELL_BITS-1:0] o_out_cell;
    logic [2:0]                     o_class_index;
    logic [gcfh_pkg::FRAC_BITS-1:0] o_fraction;
    logic                           o_last;

    // Land-cover codes with a class after reset, and that class.
    int unsigned mapped_code [N_MAPPED] = '{
        170, 150, 106, 173, 109, 102, 49, 151, 90, 157, 107, 93, 96, 122,
        19, 31, 41, 45, 32, 18, 42,
        11, 12, 44, 38, 78, 81,
        23, 25, 36, 22, 16, 24, 30,
        26, 27, 29, 28, 37, 128, 54, 92, 53, 124, 94, 73,
        139, 135, 138, 40, 116, 145, 144, 117, 137, 136, 141, 21, 147,
        120, 123, 121, 127, 126, 129, 132
    };
    int unsigned mapped_class [N_MAPPED] = '{
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
        2, 2, 2, 2, 2, 2, 2,
        3, 3, 3, 3, 3, 3,
        4, 4, 4, 4, 4, 4, 4,
        5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5,
        6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6,
        7, 7, 7, 7, 7, 7, 7
    };

    // Shadow state of the block
    logic [gcfh_pkg::CLS_BITS-1:0]  map_tbl [gcfh_pkg::TABLE_DEPTH];
    logic [gcfh_pkg::SUM_BITS-1:0]  cls_sum [gcfh_pkg::NUM_CLASSES];
    logic [gcfh_pkg::CELL_BITS-1:0] open_cell;
    logic                           cell_open;
    t_frac_word                     pending_fracs [$];

    bit          failed;
    bit          quiet;
    int unsigned long_hold;

    grouped_class_fraction_histogram_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_cell_id     (i_cell_id),
        .i_raw_code    (i_raw_code),
        .i_pixel_count (i_pixel_count),
        .i_new_class   (i_new_class),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_cell    (o_out_cell),
        .o_class_index (o_class_index),
        .o_fraction    (o_fraction),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void reset_model();
        foreach (map_tbl[i]) map_tbl[i] = '0;
        foreach (mapped_code[i])
            map_tbl[mapped_code[i]] = gcfh_pkg::CLS_BITS'(mapped_class[i]);
        foreach (cls_sum[k]) cls_sum[k] = '0;
        open_cell = '0;
        cell_open = 1'b0;
    endfunction

    // floor(part * 2^16 / whole), saturating; zero whole gives zero
    function automatic logic [gcfh_pkg::FRAC_BITS-1:0] q16_share(
            input logic [gcfh_pkg::TOT_BITS-1:0] part,
            input logic [gcfh_pkg::TOT_BITS-1:0] whole);
        logic [gcfh_pkg::TOT_BITS+gcfh_pkg::FRAC_BITS-1:0] num;
        if (whole == '0) return '0;
        if (part >= whole) return gcfh_pkg::FRAC_MAX;
        num = {part, {gcfh_pkg::FRAC_BITS{1'b0}}};
        return gcfh_pkg::FRAC_BITS'(num / whole);
    endfunction

    function automatic void emit_fractions();
        logic [gcfh_pkg::TOT_BITS:0]   acc;
        logic [gcfh_pkg::TOT_BITS-1:0] total;
        t_frac_word                    w;
        total = '0;
        for (int k = 0; k < gcfh_pkg::NUM_CLASSES; k++) begin
            acc = (gcfh_pkg::TOT_BITS+1)'(total) + (gcfh_pkg::TOT_BITS+1)'(cls_sum[k]);
            total = acc[gcfh_pkg::TOT_BITS] ? gcfh_pkg::TOT_MAX : acc[gcfh_pkg::TOT_BITS-1:0];
        end
        for (int k = 0; k < gcfh_pkg::NUM_CLASSES; k++) begin
            w.grid_cell = open_cell;
            w.cls       = 3'(k);
            w.frac      = q16_share(gcfh_pkg::TOT_BITS'(cls_sum[k]), total);
            w.last      = (k == gcfh_pkg::NUM_CLASSES - 1);
            pending_fracs.push_back(w);
        end
        foreach (cls_sum[k]) cls_sum[k] = '0;
    endfunction

    function automatic void apply_record(input t_land_rec r);
        logic [gcfh_pkg::CLS_BITS-1:0] c;
        logic [gcfh_pkg::SUM_BITS-1:0] room;
        case (r.cmd)
            gcfh_pkg::CMD_ADD: begin
                if (cell_open && r.grid_cell != open_cell) emit_fractions();
                open_cell = r.grid_cell;
                cell_open = 1'b1;
                c = map_tbl[r.code];
                room = gcfh_pkg::SUM_MAX - cls_sum[c];
                cls_sum[c] = (gcfh_pkg::SUM_BITS'(r.count) > room) ? gcfh_pkg::SUM_MAX
                             : cls_sum[c] + gcfh_pkg::SUM_BITS'(r.count);
            end
            gcfh_pkg::CMD_FLUSH: begin
                if (cell_open) begin
                    emit_fractions();
                    cell_open = 1'b0;
                end
            end
            gcfh_pkg::CMD_WRITE: begin
                map_tbl[r.code] = gcfh_pkg::CLS_BITS'(r.ncls);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_land_rec mk_rec(input logic [1:0]                     cmd,
                                         input logic [gcfh_pkg::CELL_BITS-1:0] grid_cell,
                                         input logic [gcfh_pkg::CODE_BITS-1:0] code,
                                         input logic [gcfh_pkg::CNT_BITS-1:0]  count,
                                         input logic [gcfh_pkg::NCLS_BITS-1:0] ncls);
        t_land_rec r;
        r.cmd       = cmd;
        r.grid_cell = grid_cell;
        r.code      = code;
        r.count     = count;
        r.ncls      = ncls;
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // One input transfer; the shadow model is updated at the accepting edge.
    task automatic send_rec(input t_land_rec r);
        int unsigned gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_cmd         = r.cmd;
        i_cell_id     = r.grid_cell;
        i_raw_code    = r.code;
        i_pixel_count = r.count;
        i_new_class   = r.ncls;
        do @(posedge i_clk); while (o_stall);
        apply_record(r);
    endtask

    task automatic add_rec(input logic [gcfh_pkg::CELL_BITS-1:0] grid_cell,
                           input logic [gcfh_pkg::CODE_BITS-1:0] code,
                           input logic [gcfh_pkg::CNT_BITS-1:0]  count);
        send_rec(mk_rec(gcfh_pkg::CMD_ADD, grid_cell, code, count, '0));
    endtask

    task automatic flush_cell();
        send_rec(mk_rec(gcfh_pkg::CMD_FLUSH, gcfh_pkg::CELL_BITS'($urandom),
                        gcfh_pkg::CODE_BITS'($urandom), $urandom,
                        gcfh_pkg::NCLS_BITS'($urandom)));
    endtask

    task automatic write_map(input logic [gcfh_pkg::CODE_BITS-1:0] code,
                             input logic [gcfh_pkg::NCLS_BITS-1:0] ncls);
        send_rec(mk_rec(gcfh_pkg::CMD_WRITE, gcfh_pkg::CELL_BITS'($urandom), code, $urandom,
                        ncls));
    endtask

    // Receiver: random hold-off before each transfer, or one long hold on request.
    initial begin
        int unsigned hold;
        i_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            if (long_hold != 0) begin
                hold = long_hold;
                long_hold = 0;
            end else begin
                hold = draw_gap();
            end
            repeat (hold) begin
                @(negedge i_clk);
                i_stall = 1'b1;
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
        failed = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_frac_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_fracs.size() == 0) begin
                $display("%0t: unexpected fraction: expected none, got cell %0h class %0d frac %0h",
                         $time, o_out_cell, o_class_index, o_fraction);
                failed = 1'b1;
            end else begin
                want = pending_fracs.pop_front();
                if (o_out_cell !== want.grid_cell)
                    flag_mismatch("out_cell", want.grid_cell, o_out_cell);
                if (o_class_index !== want.cls)
                    flag_mismatch("class_index", want.cls, o_class_index);
                if (o_fraction !== want.frac) flag_mismatch("fraction", want.frac, o_fraction);
                if (o_last !== want.last) flag_mismatch("last", want.last, o_last);
            end
        end
    end

    // Corner cells: empty flush, ignored command, full share, zero total, every class.
    task automatic test_cell_corners();
        flush_cell();
        send_rec(mk_rec(CMD_UNUSED, '1, '1, '1, '1));
        add_rec('0, 8'd170, '1);
        add_rec('0, 8'd0, '0);
        add_rec('1, 8'd120, 32'd1);     // cell change closes cell 0
        add_rec('1, 8'd255, '0);
        flush_cell();
        add_rec(20'd5, 8'd19, '0);
        add_rec(20'd5, 8'd11, '0);
        flush_cell();
        add_rec(20'd12345, 8'd0, 32'd1);
        add_rec(20'd12345, 8'd150, 32'd2);
        add_rec(20'd12345, 8'd31, 32'd300);
        add_rec(20'd12345, 8'd12, 32'd4000);
        add_rec(20'd12345, 8'd25, 32'd50000);
        add_rec(20'd12345, 8'd27, 32'd7);
        add_rec(20'd12345, 8'd135, 32'h8000_0000);
        add_rec(20'd12345, 8'd123, 32'd1);
        add_rec(20'd12346, 8'd81, 32'd3);
        flush_cell();
    endtask

    task automatic test_table_writes();
        write_map(8'd0, 3'd7);
        write_map(8'd255, 3'd0);
        write_map(8'd85, 3'd2);
        write_map(8'd170, 3'd5);
        add_rec(20'd77, 8'd0, 32'd10);
        add_rec(20'd77, 8'd255, 32'd20);
        add_rec(20'd77, 8'd85, 32'd30);
        add_rec(20'd77, 8'd170, 32'd40);
        flush_cell();
    endtask

    // One class sum driven past its 40-bit ceiling.
    task automatic test_sum_saturation();
        for (int i = 0; i < 258; i++) add_rec(20'hABCDE, 8'd19, '1);
        add_rec(20'hABCDE, 8'd11, 32'd1000);
        flush_cell();
    endtask

    // Receiver holds off for a long stretch while cells keep arriving.
    task automatic test_output_backpressure();
        quiet = 1'b1;
        long_hold = 400;
        for (int c = 0; c < 6; c++) begin
            add_rec(gcfh_pkg::CELL_BITS'(1000 + c), gcfh_pkg::CODE_BITS'(mapped_code[c * 7]),
                    $urandom);
            add_rec(gcfh_pkg::CELL_BITS'(1000 + c), gcfh_pkg::CODE_BITS'(mapped_code[c * 11]),
                    $urandom_range(0, 99));
            add_rec(gcfh_pkg::CELL_BITS'(1000 + c), gcfh_pkg::CODE_BITS'($urandom), $urandom);
        end
        flush_cell();
        quiet = 1'b0;
    endtask

    function automatic logic [gcfh_pkg::CODE_BITS-1:0] pick_code();
        if ($urandom_range(0, 9) < 7)
            return gcfh_pkg::CODE_BITS'(mapped_code[$urandom_range(0, N_MAPPED-1)]);
        return gcfh_pkg::CODE_BITS'($urandom_range(0, 255));
    endfunction

    function automatic logic [gcfh_pkg::CNT_BITS-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 15);
            3, 4:    return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Cells mostly in ascending order with random records, flushes, table writes and some noise.
    task automatic test_random_cells(input int unsigned n_items);
        int unsigned                    sent;
        int unsigned                    grp;
        int unsigned                    groups;
        logic [gcfh_pkg::CELL_BITS-1:0] cur_cell;
        sent = 0;
        groups = 0;
        cur_cell = gcfh_pkg::CELL_BITS'($urandom_range(0, 1000));
        while (sent < n_items) begin
            if (groups % 8 == 0) quiet = ($urandom_range(0, 3) == 0);
            groups++;
            case ($urandom_range(0, 9))
                0:       cur_cell = gcfh_pkg::CELL_BITS'($urandom);
                1:       ;   // same cell again, merges or reopens after a flush
                default: cur_cell = cur_cell + gcfh_pkg::CELL_BITS'($urandom_range(1, 40));
            endcase
            grp = $urandom_range(1, 8);
            for (int k = 0; k < grp; k++) begin
                send_rec(mk_rec(gcfh_pkg::CMD_ADD, cur_cell, pick_code(), pick_count(),
                                gcfh_pkg::NCLS_BITS'($urandom)));
                sent++;
                if ($urandom_range(0, 29) == 0)
                    send_rec(mk_rec(CMD_UNUSED, gcfh_pkg::CELL_BITS'($urandom),
                                    gcfh_pkg::CODE_BITS'($urandom), $urandom,
                                    gcfh_pkg::NCLS_BITS'($urandom)));
            end
            case ($urandom_range(0, 9))
                0, 1: begin
                    flush_cell();
                    sent++;
                end
                2: begin
                    write_map(gcfh_pkg::CODE_BITS'($urandom), gcfh_pkg::NCLS_BITS'($urandom));
                    sent++;
                end
                3: begin
                    flush_cell();
                    flush_cell();   // second one finds no open cell
                    sent++;
                end
                default: ;
            endcase
        end
        quiet = 1'b0;
        flush_cell();
    endtask

    initial begin
        failed        = 1'b0;
        quiet         = 1'b0;
        long_hold     = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = gcfh_pkg::CMD_ADD;
        i_cell_id     = '0;
        i_raw_code    = '0;
        i_pixel_count = '0;
        i_new_class   = '0;
        reset_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_cell_corners();
        test_table_writes();
        test_sum_saturation();
        test_output_backpressure();
        test_random_cells(180);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_fracs.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (failed) begin
            $display("Simulation FAILED");
        end else begin
            $display("Simulation PASSED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d fractions still expected", $time, pending_fracs.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
